// ----- hdl/pcm_pkg.sv -----
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types, register indexes and constants for the pixel colour match
// counter.
// ----------------------------------------------------------------------------
package pcm_pkg;

	localparam int DEF_NUM_RULES  = 4;
	localparam int DEF_COORD_BITS = 12;

	localparam int RGB_BITS       = 24;
	localparam int CHAN_BITS      = 8;
	localparam int BOUND_BITS     = 16;
	localparam int TOL_BITS       = 8;
	localparam int RCNT_BITS      = 3;
	localparam int RULE_IDX_BITS  = 2;
	localparam int COUNT_BITS     = 25;
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 48;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = 25'd16777216;
	localparam logic [RCNT_BITS-1:0]  RCNT_RESET = 3'd1;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_X_BOUNDS  = 4'd0,
		REG_Y_BOUNDS  = 4'd1,
		REG_TOLERANCE = 4'd2,
		REG_RULE_CNT  = 4'd3,
		REG_RULE0     = 4'd4,
		REG_RULE1     = 4'd5,
		REG_RULE2     = 4'd6,
		REG_RULE3     = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] col_r;
		logic [CHAN_BITS-1:0] col_g;
		logic [CHAN_BITS-1:0] col_b;
		logic [CHAN_BITS-1:0] dlt_r;
		logic [CHAN_BITS-1:0] dlt_g;
		logic [CHAN_BITS-1:0] dlt_b;
	} rule_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] r;
		logic [CHAN_BITS-1:0] g;
		logic [CHAN_BITS-1:0] b;
	} rgb_t;

endpackage

// ----- hdl/pixel_color_match_count.sv -----
// ----------------------------------------------------------------------------
// pixel_color_match_count
// Matches raster-order pixels inside a rectangle against colour rules,
// counts matches per frame and latches the first match position.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//  pixel   | in_valid / in_ready   | pixel_rgb, x_pos, y_pos, frame_start
//  result  | out_valid / out_ready | in_region, matched, matched_rule,
//          |                       | match_count, found, found_x, found_y
//
//  One item per clock sustained while out_ready holds. A taken item loads the
//  input register; the result register then loads from it and offers it.
//  The rule compare, region test and counter update sit between the two.
//  A stalled result holds the result register; the input register still
//  takes one more item. cfg_ready is always high.
//  Reset clears the frame state and loads the register reset values.
// ----------------------------------------------------------------------------
module pixel_color_match_count #(
	parameter int NUM_RULES  = pcm_pkg::DEF_NUM_RULES,
	parameter int COORD_BITS = pcm_pkg::DEF_COORD_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pcm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [pcm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [pcm_pkg::RGB_BITS-1:0]         pixel_rgb,
	input  logic [COORD_BITS-1:0]                x_pos,
	input  logic [COORD_BITS-1:0]                y_pos,
	input  logic                                 frame_start,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 in_region,
	output logic                                 matched,
	output logic [pcm_pkg::RULE_IDX_BITS-1:0]    matched_rule,
	output logic [pcm_pkg::COUNT_BITS-1:0]       match_count,
	output logic                                 found,
	output logic [COORD_BITS-1:0]                found_x,
	output logic [COORD_BITS-1:0]                found_y
);
	import pcm_pkg::*;

	// configuration
	logic [2*BOUND_BITS-1:0] x_bounds_q;
	logic [2*BOUND_BITS-1:0] y_bounds_q;
	logic [TOL_BITS-1:0]     tol_q;
	logic [RCNT_BITS-1:0]    rule_cnt_q;
	rule_t                   rules_q [NUM_RULES];

	// input stage
	logic                    valid_s1;
	rgb_t                    rgb_s1;
	logic [COORD_BITS-1:0]   x_s1;
	logic [COORD_BITS-1:0]   y_s1;
	logic                    start_s1;

	// frame state
	logic [COUNT_BITS-1:0]   count_q;
	logic                    found_q;
	logic [COORD_BITS-1:0]   fx_q;
	logic [COORD_BITS-1:0]   fy_q;

	logic                    advance;
	logic                    take_in;
	logic [BOUND_BITS-1:0]   x_ext;
	logic [BOUND_BITS-1:0]   y_ext;
	logic                    in_rect;
	logic [NUM_RULES-1:0]    rule_hit;
	logic                    hit;
	logic [RULE_IDX_BITS-1:0] which;
	logic [COUNT_BITS-1:0]   cnt_base;
	logic [COUNT_BITS-1:0]   cnt_next;
	logic                    found_base;
	logic [COORD_BITS-1:0]   fx_base;
	logic [COORD_BITS-1:0]   fy_base;
	logic                    found_next;
	logic [COORD_BITS-1:0]   fx_next;
	logic [COORD_BITS-1:0]   fy_next;
	logic [CFG_INDEX_BITS-1:0] rule_sel;

	assign cfg_ready = 1'b1;
	assign rule_sel  = cfg_index - REG_RULE0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_bounds_q <= '0;
			y_bounds_q <= '0;
			tol_q      <= '0;
			rule_cnt_q <= RCNT_RESET;
			for (int i = 0; i < NUM_RULES; i++) begin
				rules_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_X_BOUNDS:  x_bounds_q <= cfg_data[2*BOUND_BITS-1:0];
				REG_Y_BOUNDS:  y_bounds_q <= cfg_data[2*BOUND_BITS-1:0];
				REG_TOLERANCE: tol_q      <= cfg_data[TOL_BITS-1:0];
				REG_RULE_CNT:  rule_cnt_q <= cfg_data[RCNT_BITS-1:0];
				REG_RULE0, REG_RULE1, REG_RULE2, REG_RULE3: begin
					for (int i = 0; i < NUM_RULES; i++) begin
						if (rule_sel == CFG_INDEX_BITS'(i)) begin
							rules_q[i] <= rule_t'(cfg_data);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign advance = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign take_in = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			rgb_s1   <= rgb_t'(pixel_rgb);
			x_s1     <= x_pos;
			y_s1     <= y_pos;
			start_s1 <= frame_start;
		end
	end

	assign x_ext = BOUND_BITS'(x_s1);
	assign y_ext = BOUND_BITS'(y_s1);
	assign in_rect = (x_ext >= x_bounds_q[BOUND_BITS-1:0])
		&& (x_ext <= x_bounds_q[2*BOUND_BITS-1:BOUND_BITS])
		&& (y_ext >= y_bounds_q[BOUND_BITS-1:0])
		&& (y_ext <= y_bounds_q[2*BOUND_BITS-1:BOUND_BITS]);

	for (genvar g = 0; g < NUM_RULES; g++) begin : g_rule
		pcm_rule_match u_match (
			.pixel     (rgb_s1),
			.rule      (rules_q[g]),
			.tolerance (tol_q),
			.hit       (rule_hit[g])
		);
	end

	always_comb begin
		hit   = 1'b0;
		which = '0;
		for (int i = NUM_RULES - 1; i >= 0; i--) begin
			if (in_rect && rule_hit[i] && (RCNT_BITS'(i) < rule_cnt_q)) begin
				hit   = 1'b1;
				which = RULE_IDX_BITS'(i);
			end
		end
	end

	always_comb begin
		cnt_base   = start_s1 ? '0 : count_q;
		found_base = start_s1 ? 1'b0 : found_q;
		fx_base    = start_s1 ? '0 : fx_q;
		fy_base    = start_s1 ? '0 : fy_q;
		cnt_next   = (hit && cnt_base < COUNT_MAX) ? cnt_base + 1'b1 : cnt_base;
		found_next = found_base || hit;
		fx_next    = (hit && !found_base) ? x_s1 : fx_base;
		fy_next    = (hit && !found_base) ? y_s1 : fy_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			found_q   <= 1'b0;
			fx_q      <= '0;
			fy_q      <= '0;
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				count_q <= cnt_next;
				found_q <= found_next;
				fx_q    <= fx_next;
				fy_q    <= fy_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			in_region    <= in_rect;
			matched      <= hit;
			matched_rule <= which;
		end
	end

	assign match_count = count_q;
	assign found       = found_q;
	assign found_x     = fx_q;
	assign found_y     = fy_q;

endmodule

// ----- hdl/pcm_rule_match.sv -----
// ----------------------------------------------------------------------------
// pcm_rule_match
// Compares one pixel with one colour rule: every channel must lie within
// the larger of the global tolerance and the rule's own delta.
// ----------------------------------------------------------------------------
module pcm_rule_match (
	input  pcm_pkg::rgb_t                    pixel,
	input  pcm_pkg::rule_t                   rule,
	input  logic [pcm_pkg::TOL_BITS-1:0]     tolerance,
	output logic                             hit
);
	import pcm_pkg::*;

	function automatic logic chan_ok(
		input logic [CHAN_BITS-1:0] p,
		input logic [CHAN_BITS-1:0] c,
		input logic [CHAN_BITS-1:0] delta,
		input logic [TOL_BITS-1:0]  tol
	);
		logic [CHAN_BITS-1:0] diff;
		logic [CHAN_BITS-1:0] lim;
		diff = (p >= c) ? p - c : c - p;
		lim  = (tol > delta) ? tol : delta;
		return diff <= lim;
	endfunction

	assign hit = chan_ok(pixel.r, rule.col_r, rule.dlt_r, tolerance)
		&& chan_ok(pixel.g, rule.col_g, rule.dlt_g, tolerance)
		&& chan_ok(pixel.b, rule.col_b, rule.dlt_b, tolerance);

endmodule

// ----- hdl/pcm_checker.sv -----
// ----------------------------------------------------------------------------
// pcm_checker
// Port-level checks on the pixel colour match counter, bound to the top
// level.
// ----------------------------------------------------------------------------
module pcm_checker #(
	parameter int COORD_BITS = pcm_pkg::DEF_COORD_BITS
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               in_region,
	input logic                               matched,
	input logic [pcm_pkg::RULE_IDX_BITS-1:0]  matched_rule,
	input logic [pcm_pkg::COUNT_BITS-1:0]     match_count,
	input logic                               found,
	input logic [COORD_BITS-1:0]              found_x,
	input logic [COORD_BITS-1:0]              found_y
);
	import pcm_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_count) && $stable(found))
		else $error("result changed while stalled");

	a_match_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matched |-> in_region && found && (match_count != '0))
		else $error("match outside region or not counted");

	a_rule_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !matched |-> matched_rule == '0)
		else $error("rule index set without a match");

	a_found_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> found_x == '0 && found_y == '0 && match_count == '0)
		else $error("first-match latch set without a match");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_count <= COUNT_MAX)
		else $error("match count beyond saturation");

endmodule

bind pixel_color_match_count pcm_checker #(.COORD_BITS(COORD_BITS)) u_pcm_checker (.*);

// ----- tb/tb_pixel_color_match_count.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_color_match_count
// Self-checking bench for the pixel colour match counter. Pixel items and
// register writes go in over valid/ready. A model of the region test, the
// first-hit rule compare and the per-frame count and latch predicts each
// result. Results are checked in order with random idling on both sides, in
// an unbroken stream, and once with the output held off to stall the input.
// ----------------------------------------------------------------------------
module tb_pixel_color_match_count;
	import pcm_pkg::*;

	localparam int COORD_W         = DEF_COORD_BITS;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int IDLE_PERCENT    = 11;
	localparam int REPORT_LIMIT    = 10;
	localparam int DRAIN_CYCLES    = 6;
	localparam int RANDOM_SETUPS   = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 4'd8;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 4'd15;
	localparam logic [BOUND_BITS-1:0]     BOUND_TOP    = 16'hffff;

	typedef struct packed {
		logic                     in_region;
		logic                     matched;
		logic [RULE_IDX_BITS-1:0] matched_rule;
		logic [COUNT_BITS-1:0]    match_count;
		logic                     found;
		logic [COORD_W-1:0]       found_x;
		logic [COORD_W-1:0]       found_y;
	} pixel_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [RGB_BITS-1:0]       pixel_rgb;
	logic [COORD_W-1:0]        x_pos;
	logic [COORD_W-1:0]        y_pos;
	logic                      frame_start;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      in_region;
	logic                      matched;
	logic [RULE_IDX_BITS-1:0]  matched_rule;
	logic [COUNT_BITS-1:0]     match_count;
	logic                      found;
	logic [COORD_W-1:0]        found_x;
	logic [COORD_W-1:0]        found_y;

	// register copies
	logic [2*BOUND_BITS-1:0] x_span;
	logic [2*BOUND_BITS-1:0] y_span;
	logic [TOL_BITS-1:0]     tolerance;
	logic [RCNT_BITS-1:0]    rules_in_use;
	rule_t                   rule_bank [DEF_NUM_RULES];

	// frame state
	logic [COUNT_BITS-1:0] hit_total;
	logic                  hit_seen;
	logic [COORD_W-1:0]    hit_x;
	logic [COORD_W-1:0]    hit_y;

	pixel_result_t expected_results [$];

	bit idle_on = 1'b1;
	int pixels_offered  = 0;
	int results_seen    = 0;
	int writes_done     = 0;
	int failures        = 0;
	int stuck_cycles    = 0;
	int hold_offs_asked = 0;
	int hold_offs_taken = 0;
	int hold_off_left   = 0;

	pixel_color_match_count dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_rgb    (pixel_rgb),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.in_region    (in_region),
		.matched      (matched),
		.matched_rule (matched_rule),
		.match_count  (match_count),
		.found        (found),
		.found_x      (found_x),
		.found_y      (found_y)
	);

	always #10 clk = ~clk;

	function automatic void apply_write(logic [CFG_INDEX_BITS-1:0] idx,
			logic [CFG_DATA_BITS-1:0] data);
		case (idx)
			REG_X_BOUNDS:  x_span = data[2*BOUND_BITS-1:0];
			REG_Y_BOUNDS:  y_span = data[2*BOUND_BITS-1:0];
			REG_TOLERANCE: tolerance = data[TOL_BITS-1:0];
			REG_RULE_CNT:  rules_in_use = data[RCNT_BITS-1:0];
			REG_RULE0:     rule_bank[0] = data;
			REG_RULE1:     rule_bank[1] = data;
			REG_RULE2:     rule_bank[2] = data;
			REG_RULE3:     rule_bank[3] = data;
			default: ;
		endcase
	endfunction

	function automatic bit chan_within(logic [CHAN_BITS-1:0] p, logic [CHAN_BITS-1:0] c,
			logic [CHAN_BITS-1:0] d);
		logic [CHAN_BITS-1:0] diff;
		logic [CHAN_BITS-1:0] limit;
		diff  = (p >= c) ? p - c : c - p;
		limit = (tolerance > d) ? tolerance : d;
		return diff <= limit;
	endfunction

	function automatic bit rule_hits(rgb_t px, rule_t rl);
		return chan_within(px.r, rl.col_r, rl.dlt_r) && chan_within(px.g, rl.col_g, rl.dlt_g)
			&& chan_within(px.b, rl.col_b, rl.dlt_b);
	endfunction

	function automatic pixel_result_t predict_pixel(rgb_t px, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic fs);
		pixel_result_t res;
		int unsigned   in_use;
		if (fs) begin
			hit_total = '0;
			hit_seen  = 1'b0;
			hit_x     = '0;
			hit_y     = '0;
		end
		in_use = (rules_in_use > DEF_NUM_RULES) ? DEF_NUM_RULES : rules_in_use;
		res = '0;
		res.in_region = x >= x_span[BOUND_BITS-1:0] && x <= x_span[2*BOUND_BITS-1:BOUND_BITS]
			&& y >= y_span[BOUND_BITS-1:0] && y <= y_span[2*BOUND_BITS-1:BOUND_BITS];
		if (res.in_region) begin
			for (int i = 0; i < in_use; i++) begin
				if (!res.matched && rule_hits(px, rule_bank[i])) begin
					res.matched      = 1'b1;
					res.matched_rule = RULE_IDX_BITS'(i);
				end
			end
		end
		if (res.matched) begin
			if (hit_total < COUNT_MAX)
				hit_total = hit_total + 1'b1;
			if (!hit_seen) begin
				hit_seen = 1'b1;
				hit_x    = x;
				hit_y    = y;
			end
		end
		res.match_count = hit_total;
		res.found       = hit_seen;
		res.found_x     = hit_x;
		res.found_y     = hit_y;
		return res;
	endfunction

	function automatic string describe(pixel_result_t r);
		return $sformatf("region=%0b match=%0b rule=%0d count=%0d found=%0b at (%0d,%0d)",
			r.in_region, r.matched, r.matched_rule, r.match_count, r.found, r.found_x,
			r.found_y);
	endfunction

	function automatic logic [CHAN_BITS-1:0] near_chan(logic [CHAN_BITS-1:0] c,
			logic [CHAN_BITS-1:0] d);
		int unsigned reach;
		reach = ((tolerance > d) ? tolerance : d) + 2;
		return CHAN_BITS'(c + $urandom_range(2 * reach) - reach);
	endfunction

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			apply_write(cfg_index, cfg_data);
		if (arst_n && in_valid && in_ready)
			expected_results = {expected_results,
				predict_pixel(pixel_rgb, x_pos, y_pos, frame_start)};
	end

	always @(posedge clk) begin : result_check
		pixel_result_t seen;
		pixel_result_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = {in_region, matched, matched_rule, match_count, found, found_x, found_y};
			results_seen++;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("result %0d with nothing expected: %s", results_seen,
						describe(seen));
			end else begin
				want = expected_results.pop_front();
				if (seen.in_region !== want.in_region || seen.matched !== want.matched
						|| seen.matched_rule !== want.matched_rule
						|| seen.match_count !== want.match_count
						|| seen.found !== want.found || seen.found_x !== want.found_x
						|| seen.found_y !== want.found_y) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("result %0d mismatch", results_seen);
						$display("  expected %s", describe(want));
						$display("  actual   %s", describe(seen));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_offs_taken != hold_offs_asked) begin
			hold_offs_taken <= hold_offs_taken + 1;
			hold_off_left   <= HOLD_OFF_CYCLES;
			out_ready       <= 1'b0;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
			out_ready     <= 1'b0;
		end else begin
			out_ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		writes_done++;
	endtask

	task automatic send_pixel(logic [RGB_BITS-1:0] rgb, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic fs);
		cfg_valid <= 1'b0;
		while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_rgb   <= rgb;
		x_pos       <= x;
		y_pos       <= y;
		frame_start <= fs;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pixels_offered++;
	endtask

	task automatic wait_drain();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (results_seen < pixels_offered)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic randomise_setup(int unsigned phase, output logic [COORD_W-1:0] ox,
			output logic [COORD_W-1:0] oy);
		logic [BOUND_BITS-1:0] lo_x;
		logic [BOUND_BITS-1:0] hi_x;
		logic [BOUND_BITS-1:0] lo_y;
		logic [BOUND_BITS-1:0] hi_y;
		logic [TOL_BITS-1:0]   tol;
		logic [RCNT_BITS-1:0]  n_rules;
		rule_t                 rl;
		lo_x = BOUND_BITS'($urandom_range(4000));
		hi_x = lo_x + BOUND_BITS'($urandom_range(40));
		lo_y = BOUND_BITS'($urandom_range(4000));
		hi_y = lo_y + BOUND_BITS'($urandom_range(20));
		case (phase % 7)
			2: begin
				lo_x = '0;
				hi_x = BOUND_TOP;
				lo_y = '0;
				hi_y = BOUND_TOP;
			end
			4: begin
				lo_y = BOUND_BITS'($urandom_range(4000, 1));
				hi_y = lo_y - 1'b1;
			end
			5: begin
				lo_x = BOUND_BITS'($urandom_range(4000, 1));
				hi_x = lo_x - 1'b1;
			end
			6: begin
				{hi_x, lo_x} = $urandom;
				{hi_y, lo_y} = $urandom;
			end
			default: ;
		endcase
		case (phase % 6)
			0: tol = '0;
			1: tol = '1;
			default: tol = TOL_BITS'($urandom_range(24));
		endcase
		case (phase % 5)
			3: n_rules = '0;
			4: n_rules = RCNT_BITS'($urandom_range(7, 5));
			default: n_rules = RCNT_BITS'($urandom_range(4, 1));
		endcase
		write_reg(REG_X_BOUNDS, CFG_DATA_BITS'({hi_x, lo_x}));
		write_reg(REG_Y_BOUNDS, CFG_DATA_BITS'({hi_y, lo_y}));
		write_reg(REG_TOLERANCE, CFG_DATA_BITS'(tol));
		write_reg(REG_RULE_CNT, CFG_DATA_BITS'(n_rules));
		for (int i = 0; i < DEF_NUM_RULES; i++) begin
			rl = rule_t'(CFG_DATA_BITS'({$urandom, $urandom}));
			if (phase % 4 != 3) begin
				rl.dlt_r = CHAN_BITS'($urandom_range(20));
				rl.dlt_g = CHAN_BITS'($urandom_range(20));
				rl.dlt_b = CHAN_BITS'($urandom_range(20));
			end
			write_reg(CFG_INDEX_BITS'(REG_RULE0 + i), rl);
		end
		if ($urandom_range(1))
			write_reg(CFG_INDEX_BITS'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
				CFG_DATA_BITS'({$urandom, $urandom}));
		ox = lo_x[COORD_W-1:0] - COORD_W'($urandom_range(3));
		oy = lo_y[COORD_W-1:0] - COORD_W'($urandom_range(2));
	endtask

	// raster-ordered frames with some stray pixels mixed in
	task automatic scan_frames(int unsigned frames, logic [COORD_W-1:0] ox,
			logic [COORD_W-1:0] oy);
		int unsigned         w;
		int unsigned         h;
		rule_t               rl;
		logic [RGB_BITS-1:0] rgb;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic                fs;
		for (int f = 0; f < frames; f++) begin
			w = $urandom_range(10, 3);
			h = $urandom_range(5, 2);
			for (int r = 0; r < h; r++) begin
				for (int c = 0; c < w; c++) begin
					rl = rule_bank[$urandom_range(DEF_NUM_RULES - 1)];
					if ($urandom_range(99) < 55)
						rgb = {near_chan(rl.col_r, rl.dlt_r), near_chan(rl.col_g, rl.dlt_g),
							near_chan(rl.col_b, rl.dlt_b)};
					else
						rgb = RGB_BITS'($urandom);
					x  = ox + COORD_W'(c);
					y  = oy + COORD_W'(r);
					fs = (r == 0 && c == 0);
					if ($urandom_range(99) < 5) begin
						x  = COORD_W'($urandom);
						y  = COORD_W'($urandom);
						fs = 1'($urandom_range(1));
					end
					send_pixel(rgb, x, y, fs);
				end
			end
		end
	endtask

	task automatic test_reset_values();
		send_pixel(24'h000000, 12'd0, 12'd0, 1'b1);
		send_pixel(24'h000001, 12'd0, 12'd0, 1'b0);
		send_pixel(24'h000000, 12'd1, 12'd0, 1'b0);
		wait_drain();
	endtask

	task automatic test_rule_order();
		write_reg(REG_X_BOUNDS, CFG_DATA_BITS'({BOUND_TOP, 16'h0000}));
		write_reg(REG_Y_BOUNDS, CFG_DATA_BITS'({BOUND_TOP, 16'h0000}));
		write_reg(REG_TOLERANCE, '0);
		write_reg(REG_RULE_CNT, CFG_DATA_BITS'(4));
		write_reg(REG_RULE0, {8'd10, 8'd20, 8'd30, 8'd0, 8'd0, 8'd0});
		write_reg(REG_RULE1, {8'd200, 8'd100, 8'd50, 8'd5, 8'd5, 8'd5});
		write_reg(REG_RULE2, {8'd200, 8'd100, 8'd50, 8'd9, 8'd9, 8'd9});
		write_reg(REG_RULE3, {8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0});
		send_pixel(24'hC86432, 12'hfff, 12'hfff, 1'b1);
		send_pixel(24'hCD5F37, 12'd10, 12'd0, 1'b0);
		send_pixel(24'hCE6432, 12'd11, 12'd0, 1'b0);
		send_pixel(24'hD15B3B, 12'd12, 12'd0, 1'b0);
		send_pixel(24'hD26432, 12'd13, 12'd0, 1'b0);
		send_pixel(24'hFFFFFF, 12'd0, 12'd0, 1'b0);
		send_pixel(24'h0A141E, 12'd1, 12'd2, 1'b0);
		send_pixel(24'h0B141E, 12'd2, 12'd2, 1'b0);
		wait_drain();
		write_reg(REG_TOLERANCE, CFG_DATA_BITS'(1));
		send_pixel(24'h0B141E, 12'd3, 12'd0, 1'b0);
		send_pixel(24'hFEFFFF, 12'd4, 12'd0, 1'b0);
		send_pixel(24'h000000, 12'd5, 12'd0, 1'b1);
		wait_drain();
	endtask

	task automatic test_corner_setups();
		// reversed column bounds
		write_reg(REG_X_BOUNDS, CFG_DATA_BITS'({16'd99, 16'd100}));
		send_pixel(24'h0A141E, 12'd99, 12'd7, 1'b1);
		send_pixel(24'h0A141E, 12'd100, 12'd7, 1'b0);
		wait_drain();
		write_reg(REG_X_BOUNDS, CFG_DATA_BITS'({BOUND_TOP, 16'h0000}));
		write_reg(REG_RULE_CNT, '0);
		send_pixel(24'h0A141E, 12'd100, 12'd7, 1'b0);
		wait_drain();
		// writes to unmapped indexes must leave every register alone
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, '1);
		write_reg(REG_RULE_CNT, CFG_DATA_BITS'(7));
		send_pixel(24'hFFFFFF, 12'd200, 12'd300, 1'b0);
		wait_drain();
		write_reg(REG_TOLERANCE, CFG_DATA_BITS'(8'hff));
		write_reg(REG_X_BOUNDS, CFG_DATA_BITS'({16'd4095, 16'd4095}));
		write_reg(REG_Y_BOUNDS, CFG_DATA_BITS'({16'd4095, 16'd4095}));
		send_pixel(24'h5A5A5A, 12'd4095, 12'd4095, 1'b1);
		send_pixel(24'h5A5A5A, 12'd4094, 12'd4095, 1'b0);
		wait_drain();
	endtask

	task automatic test_random_frames();
		logic [COORD_W-1:0] ox;
		logic [COORD_W-1:0] oy;
		for (int p = 0; p < RANDOM_SETUPS; p++) begin
			randomise_setup(p, ox, oy);
			scan_frames(4, ox, oy);
			wait_drain();
		end
	endtask

	task automatic test_unbroken_stream();
		logic [COORD_W-1:0] ox;
		logic [COORD_W-1:0] oy;
		idle_on = 1'b0;
		randomise_setup(2, ox, oy);
		scan_frames(6, ox, oy);
		wait_drain();
		idle_on = 1'b1;
	endtask

	task automatic test_output_hold_off();
		logic [COORD_W-1:0] ox;
		logic [COORD_W-1:0] oy;
		randomise_setup(0, ox, oy);
		hold_offs_asked++;
		scan_frames(3, ox, oy);
		wait_drain();
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		pixel_rgb    = '0;
		x_pos        = '0;
		y_pos        = '0;
		frame_start  = 1'b0;
		x_span       = '0;
		y_span       = '0;
		tolerance    = '0;
		rules_in_use = RCNT_RESET;
		for (int i = 0; i < DEF_NUM_RULES; i++)
			rule_bank[i] = '0;
		hit_total = '0;
		hit_seen  = 1'b0;
		hit_x     = '0;
		hit_y     = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_rule_order();
		test_corner_setups();
		test_random_frames();
		test_unbroken_stream();
		test_output_hold_off();

		if (expected_results.size() != 0) begin
			$display("%0d expected results never arrived", expected_results.size());
			failures += expected_results.size();
		end
		$display("Checked %0d pixel results after %0d register writes across %0d random setups,",
			results_seen, writes_done, RANDOM_SETUPS);
		$display("with random idling, an unbroken stream and a %0d-cycle output stall: %0d failures",
			HOLD_OFF_CYCLES, failures);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
